>>> rtl/core/queued_resource_lock_manager_assert.svh
// Assertion macros for the lock manager.
`ifndef QUEUED_RESOURCE_LOCK_MANAGER_ASSERT_SVH
`define QUEUED_RESOURCE_LOCK_MANAGER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QRLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lock manager check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QRLM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lock manager check failed");

`endif

>>> rtl/core/qrlm_pkg.sv
package qrlm_pkg;

	localparam int NUM_RESOURCES = 8;
	localparam int QUEUE_DEPTH   = 16;

	// Fixed field widths of the transaction payloads.
	localparam int RES_FIELD_W = 3;
	localparam int ID_W        = 4;
	localparam int STATUS_W    = 3;

	localparam int RES_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(NUM_RESOURCES * QUEUE_DEPTH);

	typedef enum logic [0:0] {
		KIND_REQUEST = 1'b0,
		KIND_RELEASE = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED    = 3'd0,
		ST_QUEUED     = 3'd1,
		ST_FREED      = 3'd2,
		ST_FREED_WOKE = 3'd3,
		ST_FULL       = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXEC,
		CS_DONE
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} qrlm_cmd_t;

	// Fold a resource field into range by repeated subtraction (narrow value).
	function automatic logic [RES_W-1:0] wrap_res(input logic [RES_FIELD_W-1:0] r);
		logic [RES_FIELD_W:0] v;
		v = {1'b0, r};
		for (int i = 0; i < (1 << RES_FIELD_W); i++) begin
			if (int'(v) >= NUM_RESOURCES) begin
				v = v - (RES_FIELD_W + 1)'(NUM_RESOURCES);
			end
		end
		return RES_W'(v);
	endfunction

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (int'(p) == QUEUE_DEPTH - 1) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [RES_W-1:0] r,
		input logic [PTR_W-1:0] p);
		return ADDR_W'(r) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
	endfunction

endpackage

>>> rtl/core/qrlm_req_if.sv
interface qrlm_req_if import qrlm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   kind;
	logic [RES_FIELD_W-1:0] resource;
	logic [ID_W-1:0]        requester;

	modport source (output valid, output kind, output resource, output requester,
		input ready);
	modport sink (input valid, input kind, input resource, input requester,
		output ready);
endinterface

>>> rtl/core/qrlm_rsp_if.sv
interface qrlm_rsp_if import qrlm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                wake_valid;
	logic [ID_W-1:0]     wake_id;

	modport source (output valid, output status, output wake_valid, output wake_id,
		input ready);
	modport sink (input valid, input status, input wake_valid, input wake_id,
		output ready);
endinterface

>>> rtl/core/qrlm_ctl.sv
module qrlm_ctl import qrlm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output qrlm_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_next;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next   = state_q;
		req_ready    = 1'b0;
		cmd.capture  = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			CS_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_next  = CS_EXEC;
				end
			end
			CS_EXEC: begin
				cmd.exec   = 1'b1;
				state_next = CS_DONE;
			end
			CS_DONE: begin
				// hold until the output register is empty or being drained
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_next   = CS_IDLE;
				end
			end
			default: begin
				state_next = CS_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

>>> rtl/core/qrlm_dp.sv
module qrlm_dp import qrlm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  qrlm_cmd_t              cmd,
	input  logic                   kind,
	input  logic [RES_FIELD_W-1:0] resource,
	input  logic [ID_W-1:0]        requester,
	output logic [STATUS_W-1:0]    status,
	output logic                   wake_valid,
	output logic [ID_W-1:0]        wake_id
);

	// captured transaction
	logic             kind_q;
	logic [RES_W-1:0] res_q;
	logic [ID_W-1:0]  who_q;

	// per-resource lock state
	logic [NUM_RESOURCES-1:0] busy_q;
	logic [PTR_W-1:0]         head_q  [NUM_RESOURCES];
	logic [PTR_W-1:0]         tail_q  [NUM_RESOURCES];
	logic [CNT_W-1:0]         count_q [NUM_RESOURCES];

	// waiter ring storage, one segment per resource
	logic [ID_W-1:0] waiter_mem [NUM_RESOURCES * QUEUE_DEPTH];
	logic [ID_W-1:0] rd_q;

	status_t status_q;
	logic    wake_q;

	status_t             out_status_q;
	logic                out_wake_q;
	logic [ID_W-1:0]     out_id_q;

	logic             sel_busy;
	logic [PTR_W-1:0] sel_head;
	logic [PTR_W-1:0] sel_tail;
	logic [CNT_W-1:0] sel_count;
	logic             do_grant;
	logic             do_full;
	logic             do_enq;
	logic             do_wake;
	logic             do_free;

	always_comb begin
		sel_busy  = busy_q[res_q];
		sel_head  = head_q[res_q];
		sel_tail  = tail_q[res_q];
		sel_count = count_q[res_q];
		do_grant  = 1'b0;
		do_full   = 1'b0;
		do_enq    = 1'b0;
		do_wake   = 1'b0;
		do_free   = 1'b0;
		if (cmd.exec) begin
			if (kind_q == KIND_REQUEST) begin
				if (!sel_busy) begin
					do_grant = 1'b1;
				end else if (sel_count == CNT_W'(QUEUE_DEPTH)) begin
					do_full = 1'b1;
				end else begin
					do_enq = 1'b1;
				end
			end else begin
				do_free = 1'b1;
				do_wake = (sel_count != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			res_q  <= wrap_res(resource);
			who_q  <= requester;
		end
		if (cmd.exec) begin
			if (do_grant) begin
				status_q <= ST_GRANTED;
			end else if (do_full) begin
				status_q <= ST_FULL;
			end else if (do_enq) begin
				status_q <= ST_QUEUED;
			end else if (do_wake) begin
				status_q <= ST_FREED_WOKE;
			end else begin
				status_q <= ST_FREED;
			end
			wake_q <= do_wake;
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_wake_q   <= wake_q;
			out_id_q     <= wake_q ? rd_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			waiter_mem[store_addr(res_q, sel_tail)] <= who_q;
		end
		if (do_wake) begin
			rd_q <= waiter_mem[store_addr(res_q, sel_head)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < NUM_RESOURCES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (do_grant) begin
				busy_q[res_q] <= 1'b1;
			end
			if (do_free) begin
				busy_q[res_q] <= 1'b0;
			end
			if (do_enq) begin
				tail_q[res_q]  <= ring_next(sel_tail);
				count_q[res_q] <= sel_count + CNT_W'(1);
			end
			if (do_wake) begin
				head_q[res_q]  <= ring_next(sel_head);
				count_q[res_q] <= sel_count - CNT_W'(1);
			end
		end
	end

	assign status     = out_status_q;
	assign wake_valid = out_wake_q;
	assign wake_id    = out_id_q;

endmodule

>>> rtl/core/queued_resource_lock_manager.sv
// Queued resource lock manager.
// req (sink): one transaction per operation: kind (request or release),
//   resource index (wraps modulo the resource count) and requester id.
// rsp (source): exactly one transaction per accepted req transaction: status,
//   wake_valid and wake_id (zero when nobody was woken).
// A request for a free resource grants it; for a busy one the id joins
// that resource's FIFO, or status reports the queue full. A release frees
// the resource and pops the oldest waiter, which must request again.
// Sequence: an accepted transaction passes from capture through execute to
//   completion, where its response is loaded into the output register; no
//   new request is taken until the controller is back in idle. The order is
//   set by the controller around the registered read of the waiter memory.
// The response sits in an output register, so the next request is taken
//   while an earlier response waits; a stalled receiver holds the block in
//   completion until the output register drains.
// Reset (arst_n low): all resources free, all queues empty, no response
//   pending. The waiter memory is not cleared; only written entries are read.
module queued_resource_lock_manager import qrlm_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	qrlm_req_if.sink    req,
	qrlm_rsp_if.source  rsp
);

	qrlm_cmd_t cmd;

	// sequence capture, execute and completion
	qrlm_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// lock flags, queue pointers, waiter memory and response register
	qrlm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (req.kind),
		.resource   (req.resource),
		.requester  (req.requester),
		.status     (rsp.status),
		.wake_valid (rsp.wake_valid),
		.wake_id    (rsp.wake_id)
	);

`include "queued_resource_lock_manager_assert.svh"

	// an accepted transaction executes in the very next cycle
	`QRLM_ASSERT_NXT(a_accept_exec, clk, arst_n, req.valid && req.ready, cmd.exec)
	// no new request while one is executing
	`QRLM_ASSERT_NXT(a_exec_busy, clk, arst_n, cmd.exec, !req.ready)
	// a woken id is reported exactly with the release-and-woke status
	`QRLM_ASSERT_IMP(a_wake_status, clk, arst_n, rsp.valid,
		rsp.wake_valid == (rsp.status == ST_FREED_WOKE))

endmodule

>>> test/tb_queued_resource_lock_manager.sv
`timescale 1ns / 100ps

module tb_queued_resource_lock_manager;
	import qrlm_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 10;
	localparam int PHASE_ITEMS = 250;

	// One response transaction as the block should report it.
	typedef struct {
		status_t         status;
		logic            woke;
		logic [ID_W-1:0] woken_id;
	} lock_outcome_t;

	// One row of the directed table, with its response typed in.
	typedef struct {
		kind_t                  kind;
		logic [RES_FIELD_W-1:0] resource;
		logic [ID_W-1:0]        requester;
		lock_outcome_t          outcome;
	} lock_row_t;

	// A woken requester that still has to ask for its resource again.
	typedef struct {
		logic [RES_FIELD_W-1:0] resource;
		logic [ID_W-1:0]        requester;
	} retry_t;

	logic clk;
	logic arst_n;

	qrlm_req_if req_ch ();
	qrlm_rsp_if rsp_ch ();

	queued_resource_lock_manager dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the lock table: busy flags and one waiter ring per resource.
	logic            held[NUM_RESOURCES];
	logic [ID_W-1:0] waiter_ring[NUM_RESOURCES][QUEUE_DEPTH];
	int unsigned     ring_head[NUM_RESOURCES];
	int unsigned     ring_tail[NUM_RESOURCES];
	int unsigned     ring_fill[NUM_RESOURCES];

	lock_outcome_t pending_outcomes[$];
	lock_outcome_t oldest_outcome;
	lock_row_t     directed_rows[$];
	retry_t        wake_retry[$];

	int err_count      = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	always #(CLK_HALF) clk = ~clk;

	// Apply one lock operation to the shadow table and return the response
	// it must produce. Out-of-range indexes fold back into the resource set.
	function automatic lock_outcome_t apply_lock_op(input kind_t k,
		input logic [RES_FIELD_W-1:0] r, input logic [ID_W-1:0] who);
		lock_outcome_t o;
		int unsigned   idx;
		idx        = int'(r) % NUM_RESOURCES;
		o.woke     = 1'b0;
		o.woken_id = '0;
		if (k == KIND_REQUEST) begin
			if (!held[idx]) begin
				held[idx] = 1'b1;
				o.status  = ST_GRANTED;
			end else if (ring_fill[idx] >= QUEUE_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				waiter_ring[idx][ring_tail[idx]] = who;
				ring_tail[idx] = (ring_tail[idx] + 1) % QUEUE_DEPTH;
				ring_fill[idx]++;
				o.status = ST_QUEUED;
			end
		end else begin
			held[idx] = 1'b0;
			if (ring_fill[idx] > 0) begin
				o.woke     = 1'b1;
				o.woken_id = waiter_ring[idx][ring_head[idx]];
				ring_head[idx] = (ring_head[idx] + 1) % QUEUE_DEPTH;
				ring_fill[idx]--;
				o.status = ST_FREED_WOKE;
			end else begin
				o.status = ST_FREED;
			end
		end
		return o;
	endfunction

	function automatic lock_outcome_t outcome(input status_t st,
		input logic woke = 1'b0, input logic [ID_W-1:0] id = '0);
		lock_outcome_t o;
		o.status   = st;
		o.woke     = woke;
		o.woken_id = id;
		return o;
	endfunction

	task automatic add_row(input kind_t k, input int r, input int who,
		input lock_outcome_t o);
		lock_row_t row;
		row.kind      = k;
		row.resource  = r[RES_FIELD_W-1:0];
		row.requester = who[ID_W-1:0];
		row.outcome   = o;
		directed_rows.push_back(row);
	endtask

	// Drive one transaction at the falling edge after a random idle gap, hold
	// it until the block takes it, then log the response it must produce.
	// Typed rows still run through the shadow table so its state stays in step.
	task automatic send_lock_op(input kind_t k, input logic [RES_FIELD_W-1:0] r,
		input logic [ID_W-1:0] who, input bit typed, input lock_outcome_t typed_o);
		lock_outcome_t o;
		retry_t        rt;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		req_ch.valid     <= 1'b1;
		req_ch.kind      <= k;
		req_ch.resource  <= r;
		req_ch.requester <= who;
		do @(posedge clk); while (!req_ch.ready);
		o = apply_lock_op(k, r, who);
		if (o.woke) begin
			rt.resource  = r;
			rt.requester = o.woken_id;
			wake_retry.push_back(rt);
		end
		pending_outcomes.push_back(typed ? typed_o : o);
	endtask

	// Drop valid and hold off until every outstanding response has come back.
	task automatic drain_responses();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	// Receiver: stall at random, decided at each falling edge.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Response checker: compare each accepted response with the oldest
	// outstanding expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("response with no outstanding transaction: status %0d",
					rsp_ch.status);
				err_count++;
			end else begin
				oldest_outcome = pending_outcomes.pop_front();
				if (rsp_ch.status !== oldest_outcome.status) begin
					$error("status: expected %0d, got %0d",
						oldest_outcome.status, rsp_ch.status);
					err_count++;
				end
				if (rsp_ch.wake_valid !== oldest_outcome.woke) begin
					$error("wake_valid: expected %0d, got %0d",
						oldest_outcome.woke, rsp_ch.wake_valid);
					err_count++;
				end
				if (rsp_ch.wake_id !== oldest_outcome.woken_id) begin
					$error("wake_id: expected %0d, got %0d",
						oldest_outcome.woken_id, rsp_ch.wake_id);
					err_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		kind_t                  k;
		logic [RES_FIELD_W-1:0] r;
		logic [ID_W-1:0]        who;
		retry_t                 rt;
		int                     req_pct;
		clk              = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.kind      = 1'b0;
		req_ch.resource  = '0;
		req_ch.requester = '0;
		rsp_ch.ready     = 1'b0;
		req_pct          = 50;
		for (int i = 0; i < NUM_RESOURCES; i++) begin
			held[i]      = 1'b0;
			ring_head[i] = 0;
			ring_tail[i] = 0;
			ring_fill[i] = 0;
		end

		// Directed table: extreme fields, both operations, release of a free
		// resource, release by a non-holder, repeated requests and a full queue.
		add_row(KIND_REQUEST, 0, 0, outcome(ST_GRANTED));
		add_row(KIND_RELEASE, 7, 15, outcome(ST_FREED));
		add_row(KIND_REQUEST, 7, 15, outcome(ST_GRANTED));
		add_row(KIND_REQUEST, 7, 5, outcome(ST_QUEUED));
		add_row(KIND_REQUEST, 7, 5, outcome(ST_QUEUED));
		add_row(KIND_RELEASE, 7, 15, outcome(ST_FREED_WOKE, 1'b1, 4'd5));
		add_row(KIND_RELEASE, 7, 0, outcome(ST_FREED_WOKE, 1'b1, 4'd5));
		add_row(KIND_RELEASE, 7, 0, outcome(ST_FREED));
		add_row(KIND_REQUEST, 3, 9, outcome(ST_GRANTED));
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			add_row(KIND_REQUEST, 3, i, outcome(ST_QUEUED));
		end
		add_row(KIND_REQUEST, 3, 15, outcome(ST_FULL));
		add_row(KIND_RELEASE, 3, 9, outcome(ST_FREED_WOKE, 1'b1, 4'd0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table with light idling at the sender and heavy stalls at the receiver.
		send_idle_pct  = 7;
		recv_stall_pct = 46;
		foreach (directed_rows[i]) begin
			send_lock_op(directed_rows[i].kind, directed_rows[i].resource,
				directed_rows[i].requester, 1'b1, directed_rows[i].outcome);
		end
		wake_retry.delete();

		// Random part in three idling phases; the sender holds off until every
		// response is back before each new phase.
		for (int phase = 0; phase < 3; phase++) begin
			drain_responses();
			case (phase)
				0: begin
					send_idle_pct  = 7;
					recv_stall_pct = 46;
				end
				1: begin
					send_idle_pct  = 46;
					recv_stall_pct = 7;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Shift the request mix now and then so queues fill up and drain.
				if (n % 40 == 0) begin
					req_pct = $urandom_range(30, 80);
				end
				if (wake_retry.size() != 0 && $urandom_range(99) < 60) begin
					// Woken requester asks again, as its retry loop would.
					rt = wake_retry.pop_front();
					send_lock_op(KIND_REQUEST, rt.resource, rt.requester, 1'b0,
						outcome(ST_GRANTED));
				end else begin
					k   = ($urandom_range(99) < req_pct) ? KIND_REQUEST : KIND_RELEASE;
					// Favor a few hot resources so their queues get deep.
					r   = ($urandom_range(99) < 70) ? RES_FIELD_W'($urandom_range(0, 2))
						: RES_FIELD_W'($urandom_range(0, NUM_RESOURCES - 1));
					who = ID_W'($urandom_range(0, 15));
					send_lock_op(k, r, who, 1'b0, outcome(ST_GRANTED));
				end
			end
		end

		drain_responses();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0 && pending_outcomes.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/qrlm_pkg.sv
rtl/core/qrlm_req_if.sv
rtl/core/qrlm_rsp_if.sv
rtl/core/qrlm_ctl.sv
rtl/core/qrlm_dp.sv
rtl/core/queued_resource_lock_manager.sv
test/tb_queued_resource_lock_manager.sv
